// ----- rtl/core/touch_gesture_recognizer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Touch gesture recogniser assertion macros
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_RECOGNIZER_TOP_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_TOP_ASSERT_SVH

// same-cycle implication
`define TGR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgr same-cycle check failed");

// next-cycle implication
`define TGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgr next-cycle check failed");

`endif

// ----- rtl/core/tgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, widths and reset values of the touch gesture recogniser.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int MS_WIDTH   = 16;
  localparam int IDX_WIDTH  = 2;

  localparam logic [MS_WIDTH-1:0] LONG_PRESS_RESET = MS_WIDTH'(600);
  localparam logic [MS_WIDTH-1:0] WINDOW_RESET     = MS_WIDTH'(320);

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_ENABLE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GEST_CLICK  = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_TRIPLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [MS_WIDTH-1:0] hold_limit_ms;
    logic [MS_WIDTH-1:0] window_ms;
    logic                multi_enable;
    logic                clear_tally;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    gesture_t gesture;
  } res_t;

  typedef struct packed {
    logic s1_valid;
    logic fire;
    logic held;
    logic long_reported;
  } stat_t;

  // counted clicks to the gesture they report; three means triple
  function automatic gesture_t tally_gesture(input logic [1:0] tally);
    gesture_t g;
    case (tally)
      2'd3:    g = GEST_TRIPLE;
      2'd2:    g = GEST_DOUBLE;
      default: g = GEST_CLICK;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/tgr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_cfg
// Configuration registers; a write to the enable register clears the tally.
// ----------------------------------------------------------------------------
module tgr_cfg import tgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [MS_WIDTH-1:0]  cfg_data,
  output cfg_t                 cfg
);

  logic [MS_WIDTH-1:0] hold_limit_ms;
  logic [MS_WIDTH-1:0] window_ms;
  logic                multi_enable;
  logic                clear_tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit_ms <= LONG_PRESS_RESET;
      window_ms     <= WINDOW_RESET;
      multi_enable  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS: hold_limit_ms <= cfg_data;
        REG_WINDOW:     window_ms     <= cfg_data;
        REG_ENABLE:     multi_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign clear_tally = cfg_write && (cfg_reg_t'(cfg_index) == REG_ENABLE);

  assign cfg = '{hold_limit_ms: hold_limit_ms, window_ms: window_ms,
                 multi_enable: multi_enable, clear_tally: clear_tally};

endmodule

// ----- rtl/core/tgr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_core
// Sample register and the combinational gesture state update behind it.
// ----------------------------------------------------------------------------
module tgr_core import tgr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  pressed,
  input  logic [TIME_WIDTH-1:0] time_ms,
  input  cfg_t                  cfg,
  input  logic                  space,
  output res_t                  res,
  output stat_t                 stat
);

  logic                  s1_valid;
  logic                  s1_pressed;
  logic [TIME_WIDTH-1:0] s1_time;

  logic                  held, held_next;
  logic                  long_reported, long_reported_next;
  logic [TIME_WIDTH-1:0] press_time, press_time_next;
  logic [TIME_WIDTH-1:0] release_time, release_time_next;
  logic [1:0]            tally, tally_next;

  logic                  fire;
  logic                  load;
  logic                  reported;
  logic                  long_due;
  logic                  window_due;
  logic [TIME_WIDTH-1:0] since_press;
  logic [TIME_WIDTH-1:0] since_release;

  assign fire     = s1_valid && space;
  assign in_stall = s1_valid && !fire;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pressed <= pressed;
      s1_time    <= time_ms;
    end
  end

  // differences wrap with the timestamp
  assign since_press   = s1_time - press_time;
  assign since_release = s1_time - release_time_next;
  assign long_due      = since_press >= TIME_WIDTH'(cfg.hold_limit_ms);
  assign window_due    = since_release >= TIME_WIDTH'(cfg.window_ms);

  always_comb begin
    held_next          = held;
    long_reported_next = long_reported;
    press_time_next    = press_time;
    release_time_next  = release_time;
    tally_next         = tally;
    res                = '{valid: 1'b0, gesture: GEST_CLICK};
    reported           = 1'b0;
    if (fire) begin
      if (s1_pressed && !held) begin
        held_next          = 1'b1;
        long_reported_next = 1'b0;
        press_time_next    = s1_time;
      end else if (s1_pressed && !long_reported && long_due) begin
        long_reported_next = 1'b1;
        tally_next         = 2'd0;
        res                = '{valid: 1'b1, gesture: GEST_LONG};
        reported           = 1'b1;
      end else if (!s1_pressed && held) begin
        held_next = 1'b0;
        if (!long_reported) begin
          if (!cfg.multi_enable) begin
            res      = '{valid: 1'b1, gesture: GEST_CLICK};
            reported = 1'b1;
          end else begin
            // saturate at three
            tally_next        = (tally == 2'd3) ? 2'd3 : tally + 2'd1;
            release_time_next = s1_time;
          end
        end
      end
      if (!reported && !held_next && (tally_next != 2'd0) && window_due) begin
        res        = '{valid: 1'b1, gesture: tally_gesture(tally_next)};
        tally_next = 2'd0;
      end
    end
    if (cfg.clear_tally) begin
      tally_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= 1'b0;
      long_reported <= 1'b0;
      press_time    <= '0;
      release_time  <= '0;
      tally         <= 2'd0;
    end else begin
      held          <= held_next;
      long_reported <= long_reported_next;
      press_time    <= press_time_next;
      release_time  <= release_time_next;
      tally         <= tally_next;
    end
  end

  assign stat = '{s1_valid: s1_valid, fire: fire, held: held,
                  long_reported: long_reported};

endmodule

// ----- rtl/core/tgr_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_outq
// Two-word result queue; keeps the sample stage moving while a word waits.
// ----------------------------------------------------------------------------
module tgr_outq import tgr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  res_t       res,
  output logic       space,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] gesture
);

  gesture_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push      = res.valid;
  assign out_valid = count != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign space     = (count != 2'd2) || pop;
  assign gesture   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= res.gesture;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/touch_gesture_recognizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top
// Turns timestamped touch samples into click, double, triple and long press.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------
//  in      | in_valid / in_stall        | pressed, time_ms[31:0]
//  out     | out_valid / out_stall      | gesture[1:0]
//  cfg     | cfg_write (no back-pressure)| cfg_index[1:0], cfg_data[15:0]
//
// One sample per cycle unless stalled. A sample waits in the sample register
// until the result queue has space; its word, if any, is queued as it leaves.
// Reset is synchronous; no clearing pass follows. The result queue holds two
// words; a full queue that is not being read stalls the sample stage.
// ----------------------------------------------------------------------------
`include "touch_gesture_recognizer_top_assert.svh"

module touch_gesture_recognizer_top import tgr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [IDX_WIDTH-1:0]  cfg_index,
  input  logic [MS_WIDTH-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  pressed,
  input  logic [TIME_WIDTH-1:0] time_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            gesture
);

  cfg_t  cfg;
  res_t  res;
  stat_t stat;
  logic  space;
  logic  long_word;

  tgr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pressed  (pressed),
    .time_ms  (time_ms),
    .cfg      (cfg),
    .space    (space),
    .res      (res),
    .stat     (stat)
  );

  tgr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gesture   (gesture)
  );

  assign long_word = res.valid && (res.gesture == GEST_LONG);

  // a long press leaves the touch held and marked as reported
  `TGR_ASSERT_NEXT(a_long_marks, clk, rst, long_word, stat.held && stat.long_reported)
  `TGR_ASSERT_IMPL(a_stall_needs_sample, clk, rst, in_stall, stat.s1_valid)
  `TGR_ASSERT_IMPL(a_word_from_fire, clk, rst, res.valid, stat.fire)
  // a sample that cannot advance stays put
  `TGR_ASSERT_NEXT(a_sample_held, clk, rst, stat.s1_valid && !stat.fire, stat.s1_valid)

endmodule

// ----- test/touch_gesture_recognizer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top_tb
// Feeds timestamped touch samples through the recogniser with random gaps and
// back-pressure. A behavioural tracker predicts every gesture word, and each
// received word is checked in order. Register settings change between phases.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top_tb;
  import tgr_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int MAX_WAIT    = 13;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 4000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1650;
  localparam int RAND_PHASES = 8;
  localparam int PRINT_CAP   = 200;

  localparam logic [IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                  pressed;
    logic [TIME_WIDTH-1:0] stamp;
  } touch_sample_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IDX_WIDTH-1:0]  cfg_index = '0;
  logic [MS_WIDTH-1:0]   cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  pressed   = 1'b0;
  logic [TIME_WIDTH-1:0] time_ms   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            gesture;

  // gesture tracker: configuration and state
  logic [MS_WIDTH-1:0]   trk_long_ms   = LONG_PRESS_RESET;
  logic [MS_WIDTH-1:0]   trk_window_ms = WINDOW_RESET;
  logic                  trk_multi     = 1'b0;
  logic                  trk_held      = 1'b0;
  logic                  trk_long_done = 1'b0;
  logic [TIME_WIDTH-1:0] trk_press_t   = '0;
  logic [TIME_WIDTH-1:0] trk_release_t = '0;
  logic [1:0]            trk_tally     = '0;

  touch_sample_t         sample_q[$];
  gesture_t              gesture_q[$];
  touch_sample_t         next_sample;
  logic [TIME_WIDTH-1:0] stamp_now;

  bit sample_taken = 1'b0;
  bit word_taken   = 1'b0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;
  int send_gap     = 0;
  int stall_left   = 0;
  int cycle_cnt    = 0;
  int samples_sent = 0;
  int queued       = 0;
  int settings_cnt = 0;
  int mismatches   = 0;
  int gesture_count[4];

  touch_gesture_recognizer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pressed   (pressed),
    .time_ms   (time_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gesture   (gesture)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // advance the tracker by one sample; returns 1 when a gesture word is due
  function automatic bit track_sample(input logic touch, input logic [TIME_WIDTH-1:0] now,
                                      output gesture_t word);
    logic [TIME_WIDTH-1:0] since_press;
    logic [TIME_WIDTH-1:0] since_release;
    word = GEST_CLICK;
    since_press = now - trk_press_t;
    if (touch && !trk_held) begin
      trk_held      = 1'b1;
      trk_long_done = 1'b0;
      trk_press_t   = now;
    end else if (touch && !trk_long_done && since_press >= TIME_WIDTH'(trk_long_ms)) begin
      trk_long_done = 1'b1;
      trk_tally     = '0;
      word          = GEST_LONG;
      return 1'b1;
    end else if (!touch && trk_held) begin
      trk_held = 1'b0;
      if (!trk_long_done) begin
        // single clicks go out at once when multi-click is off
        if (!trk_multi) return 1'b1;
        if (trk_tally != 2'd3) trk_tally = trk_tally + 2'd1;
        trk_release_t = now;
      end
    end
    since_release = now - trk_release_t;
    if (!trk_held && trk_tally != 2'd0 && since_release >= TIME_WIDTH'(trk_window_ms)) begin
      case (trk_tally)
        2'd3:    word = GEST_TRIPLE;
        2'd2:    word = GEST_DOUBLE;
        default: word = GEST_CLICK;
      endcase
      trk_tally = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // monitor: track registers and samples, check gesture words
  always @(posedge clk) begin
    gesture_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LONG_PRESS: trk_long_ms = cfg_data;
          REG_WINDOW:     trk_window_ms = cfg_data;
          REG_ENABLE: begin
            trk_multi = cfg_data[0];
            trk_tally = '0;
          end
          default: ; // drop writes to the unused index
        endcase
      end
      if (in_valid && !in_stall) begin
        samples_sent++;
        sample_taken = 1'b1;
        if (track_sample(pressed, time_ms, want)) gesture_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        word_taken = 1'b1;
        if (gesture_q.size() == 0) begin
          report_mismatch($sformatf("unexpected gesture word %0d", gesture));
        end else begin
          want = gesture_q.pop_front();
          gesture_count[want]++;
          if (gesture !== want)
            report_mismatch($sformatf("gesture %0d, expected %0d", gesture, want));
        end
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || sample_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_sample = sample_q.pop_front();
          pressed  <= next_sample.pressed;
          time_ms  <= next_sample.stamp;
          in_valid <= 1'b1;
          if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
      sample_taken = 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (word_taken) begin
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
        word_taken = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [MS_WIDTH-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_sample(input logic touch, input logic [TIME_WIDTH-1:0] dt);
    stamp_now = stamp_now + dt;
    sample_q.push_back('{touch, stamp_now});
    queued++;
  endtask

  // hold until the sender is empty and every word has come or the drain limit is hit, then let it settle
  task automatic drain_results();
    int waited;
    waited = 0;
    while (sample_q.size() != 0 || in_valid) @(posedge clk);
    while (gesture_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (gesture_q.size() != 0) begin
      report_mismatch($sformatf("%0d gesture words never arrived", gesture_q.size()));
      gesture_q.delete();
    end
  endtask

  // a step that stays under a nonzero limit, often just one short of it
  function automatic logic [TIME_WIDTH-1:0] short_of(input logic [TIME_WIDTH-1:0] lim);
    if (lim == 0) return '0;
    if ($urandom_range(0, 3) == 0) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [TIME_WIDTH-1:0] at_or_past(input logic [TIME_WIDTH-1:0] lim);
    case ($urandom_range(0, 3))
      0:       return lim;
      1:       return lim + 1;
      2:       return lim + $urandom_range(2, 2000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TIME_WIDTH-1:0] any_dt();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom_range(1, 20);
      2:       return $urandom_range(0, 70000);
      default: return $urandom();
    endcase
  endfunction

  // one gesture: taps, a long press, idle polling or noise
  task automatic queue_gesture();
    int kind;
    int taps;
    logic [TIME_WIDTH-1:0] lim_long;
    logic [TIME_WIDTH-1:0] lim_win;
    logic [TIME_WIDTH-1:0] hold;
    lim_long = TIME_WIDTH'(trk_long_ms);
    lim_win  = TIME_WIDTH'(trk_window_ms);
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      taps = $urandom_range(1, 5);
      for (int k = 0; k < taps; k++) begin
        queue_sample(1'b1, k == 0 ? any_dt() : short_of(lim_win));
        hold = '0;
        if ($urandom_range(0, 1) == 1) begin
          hold = short_of(lim_long);
          queue_sample(1'b1, hold);
        end
        queue_sample(1'b0, lim_long > hold ? short_of(lim_long - hold) : '0);
      end
      if ($urandom_range(0, 3) != 0) queue_sample(1'b0, at_or_past(lim_win));
    end else if (kind <= 7) begin
      queue_sample(1'b1, any_dt());
      if ($urandom_range(0, 1) == 1) queue_sample(1'b1, short_of(lim_long));
      queue_sample(1'b1, at_or_past(lim_long));
      repeat ($urandom_range(0, 2)) queue_sample(1'b1, any_dt());
      queue_sample(1'b0, any_dt());
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) queue_sample(1'b0, any_dt());
    end else begin
      repeat ($urandom_range(1, 6)) queue_sample(1'(($urandom_range(0, 1))), any_dt());
    end
  endtask

  initial begin
    logic [MS_WIDTH-1:0] long_fixed [5];
    logic [MS_WIDTH-1:0] win_fixed [5];
    logic [MS_WIDTH-1:0] lp_val;
    logic [MS_WIDTH-1:0] win_val;
    logic                en_val;
    int                  phase_start;
    int                  phase_items;
    bit                  paused;
    long_fixed  = '{16'd1, 16'd65535, 16'd0, 16'd600, 16'd40};
    win_fixed   = '{16'd65535, 16'd1, 16'd0, 16'd320, 16'd2};
    phase_items = RAND_ITEMS / RAND_PHASES;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: immediate click, long press, held after long press,
    // timestamps wrapping through zero
    settings_cnt++;
    stamp_now = 32'hFFFF_FF00;
    queue_sample(1'b1, 32'h80);
    queue_sample(1'b0, 100);
    queue_sample(1'b1, 50);
    queue_sample(1'b1, 599);
    queue_sample(1'b1, 1);
    queue_sample(1'b1, 5000);
    queue_sample(1'b0, 10);
    drain_results();

    // multi-click: double, then four taps saturating at triple
    write_reg(REG_ENABLE, 16'h0001);
    settings_cnt++;
    queue_sample(1'b1, 10);
    queue_sample(1'b0, 50);
    queue_sample(1'b1, 319);
    queue_sample(1'b0, 50);
    queue_sample(1'b0, 320);
    repeat (4) begin
      queue_sample(1'b1, 100);
      queue_sample(1'b0, 100);
    end
    queue_sample(1'b0, 400);
    drain_results();

    // zero window and zero hold limit; the unused index must change nothing
    write_reg(REG_LONG_PRESS, 16'd0);
    write_reg(REG_WINDOW, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    settings_cnt++;
    queue_sample(1'b1, 5);
    queue_sample(1'b0, 0);
    queue_sample(1'b1, 1);
    queue_sample(1'b1, 0);
    queue_sample(1'b0, 0);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 5) begin
        lp_val  = long_fixed[ph];
        win_val = win_fixed[ph];
      end else begin
        lp_val  = MS_WIDTH'($urandom_range(2, 3000));
        win_val = MS_WIDTH'($urandom_range(2, 1500));
      end
      en_val = (ph != 0 && ph != 4);
      write_reg(REG_LONG_PRESS, lp_val);
      write_reg(REG_WINDOW, win_val);
      // upper bits of the enable word are noise
      if (ph % 3 != 2) write_reg(REG_ENABLE, {15'($urandom()), en_val});
      if (ph == 6) write_reg(REG_UNUSED, 16'($urandom()));
      settings_cnt++;
      stamp_now   = $urandom();
      phase_start = queued;
      paused      = 1'b0;
      while (queued - phase_start < phase_items) begin
        queue_gesture();
        // pause the sender mid-phase until every word is back
        if (!paused && queued - phase_start >= phase_items / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end

    $display("Run sent %0d touch samples under %0d register settings.",
             samples_sent, settings_cnt);
    $display("Gesture words checked: %0d click, %0d double, %0d triple, %0d long press.",
             gesture_count[GEST_CLICK], gesture_count[GEST_DOUBLE],
             gesture_count[GEST_TRIPLE], gesture_count[GEST_LONG]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
